// ===== src/chev_pkg.sv =====
// Shared types and constants for the complex polynomial evaluator.
package chev_pkg;

	localparam int unsigned WORD_W = 32;
	// Width of a three-term sum of floor-shifted products; holds any shift amount.
	localparam int unsigned SUM_W = 2 * WORD_W + 2;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	typedef struct packed {
		logic signed [WORD_W-1:0] im;
		logic signed [WORD_W-1:0] re;
	} cplx_t;

	// Saturate a wide sum to one word and flag it when clipped.
	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v,
			output logic ovf);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		begin
			hi = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
			lo = ~hi;
			ovf = 1'b0;
			if (v > hi) begin
				ovf = 1'b1;
				sat_word = hi[WORD_W-1:0];
			end else if (v < lo) begin
				ovf = 1'b1;
				sat_word = lo[WORD_W-1:0];
			end else begin
				sat_word = v[WORD_W-1:0];
			end
		end
	endfunction

endpackage

// ===== src/complex_horner_eval_with_derivative.sv =====
// Top level: coefficient cells chained from the highest index down to zero.
//  channel | dir | data
//  s_axis  | in  | tdata: coef_index, coef_re, coef_im, z_re, z_im; tuser: func
//  m_axis  | out | tdata: value_re, value_im, deriv_re, deriv_im; tuser: overflow
//  cfg     | in  | data: degree
// A load completes with its transfer and does not make the block busy. An evaluation starts
// with a = d = 0 at cell n = min(degree, MAX_DEGREE), moves down to cell 0, then passes cell 0
// once more with a zero addend for the final multiply by z. Each pass has a product phase and
// then a sum and saturate phase; the finished result is then registered into m_axis_tdata.
// One evaluation in flight; a finished one holds in the sum stage while the output
// register is full. Reset clears control and sets degree to 1, not the coefficients.
module complex_horner_eval_with_derivative #(
	parameter int unsigned MAX_DEGREE = 8,
	parameter int unsigned FRAC_BITS  = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // coef_index[3:0], coef_re, coef_im, z_re, z_im
	input  logic         s_axis_tuser,  // func
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // value_re, value_im, deriv_re, deriv_im
	output logic         m_axis_tuser,  // overflow
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [3:0]   cfg_data       // degree
);
	localparam int unsigned N = MAX_DEGREE + 1;
	localparam int unsigned IW = $clog2(N);

	logic [3:0] degree_q;
	logic busy_q, phase_q, fin_q, ovf_q;
	logic [IW-1:0] pos_q;   // current cell
	chev_pkg::cplx_t z_q, a_q, d_q;
	chev_pkg::cplx_t a_c [N];
	chev_pkg::cplx_t d_c [N];
	logic [N-1:0] ovf_c;
	logic acc, eval_acc, step_en, out_free, done;
	logic [3:0] idx_in;
	logic [IW-1:0] start;
	chev_pkg::cplx_t coef_in, z_in;

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !busy_q;
	assign cfg_ready = 1'b1;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign eval_acc = acc && (s_axis_tuser == chev_pkg::FUNC_EVAL);
	assign idx_in = s_axis_tdata[3:0];
	assign coef_in = {s_axis_tdata[67:36], s_axis_tdata[35:4]};
	assign z_in = {s_axis_tdata[131:100], s_axis_tdata[99:68]};
	assign start = (32'(degree_q) > MAX_DEGREE) ? IW'(MAX_DEGREE) : IW'(degree_q);
	assign step_en = busy_q && !phase_q;
	assign done = busy_q && phase_q && fin_q && out_free;

	// The final pass reuses cell 0 with a zero addend.
	for (genvar k = 0; k < N; k++) begin : g_cell
		logic ld, act;
		assign ld = acc && (s_axis_tuser == chev_pkg::FUNC_LOAD) && (32'(idx_in) == k);
		assign act = step_en && (pos_q == IW'(k));
		chev_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
			.clk(clk), .ld(ld), .coef_in(coef_in),
			.step_a(act), .step_b(act), .use_coef(!fin_q),
			.z(z_q), .a_in(a_q), .d_in(d_q),
			.a_out(a_c[k]), .d_out(d_c[k]), .ovf(ovf_c[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= 4'd1;
			busy_q <= 1'b0;
			phase_q <= 1'b0;
			fin_q <= 1'b0;
			pos_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				degree_q <= cfg_data;
			if (eval_acc) begin
				busy_q <= 1'b1;
				phase_q <= 1'b0;
				fin_q <= 1'b0;
				pos_q <= start;
			end else if (busy_q && !phase_q) begin
				phase_q <= 1'b1;
			end else if (busy_q) begin
				if (fin_q) begin
					// hold the finished sum until the output register frees up
					if (out_free) begin
						busy_q <= 1'b0;
						phase_q <= 1'b0;
					end
				end else begin
					phase_q <= 1'b0;
					if (pos_q == '0)
						fin_q <= 1'b1;
					else
						pos_q <= pos_q - IW'(1);
				end
			end
			if (done)
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_acc) begin
			z_q <= z_in;
			a_q <= '0;
			d_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q && phase_q && !fin_q) begin
			a_q <= a_c[pos_q];
			d_q <= d_c[pos_q];
			ovf_q <= ovf_q | ovf_c[pos_q];
		end
		if (done) begin
			m_axis_tdata <= {d_c[0].im, d_c[0].re, a_c[0].im, a_c[0].re};
			m_axis_tuser <= ovf_q | ovf_c[0];
		end
	end
endmodule

// ===== src/chev_mac.sv =====
// Complex multiply-add unit: registered products, then a combinational sum and saturate.
module chev_mac #(
	parameter int unsigned FRAC_BITS = 24
) (
	input  logic           clk,
	input  logic           en,
	input  chev_pkg::cplx_t add_in,
	input  chev_pkg::cplx_t z,
	input  chev_pkg::cplx_t x,
	output chev_pkg::cplx_t res,
	output logic           ovf
);
	localparam int unsigned W = chev_pkg::WORD_W;
	localparam int unsigned PW = 2 * W;
	localparam int unsigned SW = chev_pkg::SUM_W;

	logic signed [PW-1:0] rr_s1, ii_s1, ri_s1, ir_s1;
	chev_pkg::cplx_t add_s1;
	logic signed [SW-1:0] sre, sim;
	logic ovf_re, ovf_im;

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s1 <= PW'(z.re) * PW'(x.re);
			ii_s1 <= PW'(z.im) * PW'(x.im);
			ri_s1 <= PW'(z.re) * PW'(x.im);
			ir_s1 <= PW'(z.im) * PW'(x.re);
			add_s1 <= add_in;
		end
	end

	always_comb begin
		sre = SW'(add_s1.re) + SW'(rr_s1 >>> FRAC_BITS) - SW'(ii_s1 >>> FRAC_BITS);
		sim = SW'(add_s1.im) + SW'(ri_s1 >>> FRAC_BITS) + SW'(ir_s1 >>> FRAC_BITS);
		res.re = chev_pkg::sat_word(sre, ovf_re);
		res.im = chev_pkg::sat_word(sim, ovf_im);
		ovf = ovf_re | ovf_im;
	end
endmodule

// ===== src/chev_cell.sv =====
// One Horner cell: holds a coefficient and steps value and derivative.
module chev_cell #(
	parameter int unsigned FRAC_BITS = 24
) (
	input  logic            clk,
	input  logic            ld,
	input  chev_pkg::cplx_t coef_in,
	input  logic            step_a,
	input  logic            step_b,
	input  logic            use_coef,
	input  chev_pkg::cplx_t z,
	input  chev_pkg::cplx_t a_in,
	input  chev_pkg::cplx_t d_in,
	output chev_pkg::cplx_t a_out,
	output chev_pkg::cplx_t d_out,
	output logic            ovf
);
	chev_pkg::cplx_t coef_q;
	chev_pkg::cplx_t add_a;
	logic ovf_a, ovf_d;

	always_ff @(posedge clk) begin
		if (ld)
			coef_q <= coef_in;
	end

	always_comb begin
		add_a = use_coef ? coef_q : '0;
	end

	chev_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_a (
		.clk(clk), .en(step_a), .add_in(add_a), .z(z), .x(a_in), .res(a_out), .ovf(ovf_a)
	);
	chev_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_d (
		.clk(clk), .en(step_b), .add_in(a_in), .z(z), .x(d_in), .res(d_out), .ovf(ovf_d)
	);

	assign ovf = ovf_a | ovf_d;
endmodule

// ===== bench/tb_complex_horner_eval_with_derivative.sv =====
// Testbench for the complex Horner evaluator with derivative: directed and random stream checks.
module tb_complex_horner_eval_with_derivative;

	localparam int MAX_DEG = 8;
	localparam int FRAC = 24;
	localparam int SETTLE = 2 * (MAX_DEG + 2) + 10;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RX_HOLD = 300;
	localparam logic signed [31:0] W_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] W_MIN = 32'sh80000000;
	localparam logic signed [31:0] ONE = 32'sh01000000;

	typedef struct {
		chev_pkg::cplx_t value;
		chev_pkg::cplx_t deriv;
		logic            ovf;
	} eval_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;   // coef_index, coef_re, coef_im, z_re, z_im
	logic         s_axis_tuser;   // func
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;   // value_re, value_im, deriv_re, deriv_im
	logic         m_axis_tuser;   // overflow
	logic         cfg_valid;
	logic         cfg_ready;
	logic [3:0]   cfg_data;

	chev_pkg::cplx_t coef_mem [0:MAX_DEG];
	logic [3:0]   degree_reg;
	eval_result_t pending_results [$];
	int           errors = 0;
	int           n_evals;
	int           n_loads;
	int           n_checked = 0;
	int           n_ovf = 0;
	int           rx_hold_req;
	bit           no_gaps;
	int           cycles = 0;

	complex_horner_eval_with_derivative dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic signed [31:0] clamp_word(longint v, inout bit ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return W_MAX;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return W_MIN;
		end
		return v[31:0];
	endfunction

	// add + z*x, truncating products toward minus infinity
	function automatic chev_pkg::cplx_t horner_mac(chev_pkg::cplx_t add, chev_pkg::cplx_t z,
			chev_pkg::cplx_t x, inout bit ovf);
		longint rr, ii, ri, ir;
		chev_pkg::cplx_t r;
		rr = (longint'(z.re) * longint'(x.re)) >>> FRAC;
		ii = (longint'(z.im) * longint'(x.im)) >>> FRAC;
		ri = (longint'(z.re) * longint'(x.im)) >>> FRAC;
		ir = (longint'(z.im) * longint'(x.re)) >>> FRAC;
		r.re = clamp_word(longint'(add.re) + rr - ii, ovf);
		r.im = clamp_word(longint'(add.im) + ri + ir, ovf);
		return r;
	endfunction

	function automatic eval_result_t poly_eval(chev_pkg::cplx_t z);
		int n;
		chev_pkg::cplx_t a, d, zero;
		bit ovf;
		eval_result_t res;
		n = (degree_reg > MAX_DEG) ? MAX_DEG : degree_reg;
		zero = '0;
		ovf = 1'b0;
		a = coef_mem[n];
		d = zero;
		while (n > 0) begin
			n--;
			d = horner_mac(a, z, d, ovf);
			a = horner_mac(coef_mem[n], z, a, ovf);
		end
		d = horner_mac(a, z, d, ovf);
		a = horner_mac(zero, z, a, ovf);
		res.value = a;
		res.deriv = d;
		res.ovf = ovf;
		return res;
	endfunction

	task automatic send_item(logic func, logic [3:0] idx, chev_pkg::cplx_t c,
			chev_pkg::cplx_t z);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, z.im, z.re, c.im, c.re, idx};
		s_axis_tuser <= func;
		do @(posedge clk); while (!s_axis_tready);
		if (func == chev_pkg::FUNC_LOAD) begin
			n_loads++;
			if (idx <= MAX_DEG)
				coef_mem[idx] = c;
		end else begin
			n_evals++;
			pending_results.push_back(poly_eval(z));
		end
	endtask

	task automatic load_coef(int idx, chev_pkg::cplx_t c);
		send_item(chev_pkg::FUNC_LOAD, 4'(idx), c, '{re: $urandom(), im: $urandom()});
	endtask

	task automatic eval_at(chev_pkg::cplx_t z);
		send_item(chev_pkg::FUNC_EVAL, 4'($urandom()), '{re: $urandom(), im: $urandom()}, z);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_degree(logic [3:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		degree_reg = v;
	endtask

	function automatic logic signed [31:0] rand_part();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 3) == 0 ? W_MAX : W_MIN;
			default: return 32'(int'($urandom_range(0, 2 * ONE)) - ONE);
		endcase
	endfunction

	function automatic chev_pkg::cplx_t rand_cplx();
		chev_pkg::cplx_t c;
		c.re = rand_part();
		c.im = rand_part();
		return c;
	endfunction

	// result checker
	initial begin
		eval_result_t exp_r;
		chev_pkg::cplx_t got_v, got_d;
		logic got_o;
		int stall;
		int holds_served;
		holds_served = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req != holds_served) begin
				stall = RX_HOLD;
				holds_served = rx_hold_req;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(0, 11);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got_v.re = m_axis_tdata[31:0];
			got_v.im = m_axis_tdata[63:32];
			got_d.re = m_axis_tdata[95:64];
			got_d.im = m_axis_tdata[127:96];
			got_o = m_axis_tuser;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				n_checked++;
				if (exp_r.ovf) n_ovf++;
				if (got_v.re !== exp_r.value.re) begin
					$display("%0t: value_re expected %h actual %h", $time, exp_r.value.re,
						got_v.re);
					errors++;
				end
				if (got_v.im !== exp_r.value.im) begin
					$display("%0t: value_im expected %h actual %h", $time, exp_r.value.im,
						got_v.im);
					errors++;
				end
				if (got_d.re !== exp_r.deriv.re) begin
					$display("%0t: deriv_re expected %h actual %h", $time, exp_r.deriv.re,
						got_d.re);
					errors++;
				end
				if (got_d.im !== exp_r.deriv.im) begin
					$display("%0t: deriv_im expected %h actual %h", $time, exp_r.deriv.im,
						got_d.im);
					errors++;
				end
				if (got_o !== exp_r.ovf) begin
					$display("%0t: overflow expected %b actual %b", $time, exp_r.ovf, got_o);
					errors++;
				end
			end
		end
	end

	task automatic test_fill_table();
		load_coef(0, '{re: ONE, im: 32'sd0});
		load_coef(1, '{re: W_MAX, im: W_MIN});
		load_coef(2, '{re: W_MIN, im: W_MAX});
		load_coef(3, '{re: -ONE, im: ONE});
		load_coef(4, '{re: 32'sd0, im: 32'sd0});
		load_coef(5, '{re: 32'sd1, im: -32'sd1});
		for (int i = 6; i <= MAX_DEG; i++)
			load_coef(i, rand_cplx());
	endtask

	task automatic test_degree_edges();
		logic [3:0] degs [3] = '{4'd0, 4'd15, 4'd1};
		foreach (degs[k]) begin
			set_degree(degs[k]);
			eval_at('{re: W_MAX, im: W_MAX});
			eval_at('{re: W_MIN, im: W_MIN});
			eval_at('{re: 32'sd0, im: 32'sd0});
			eval_at('{re: ONE >>> 1, im: -(ONE >>> 2)});
		end
	endtask

	// loads beyond the table are dropped; they must not disturb later evaluations
	task automatic test_ignored_loads();
		for (int i = MAX_DEG + 1; i < 16; i++)
			load_coef(i, '{re: W_MAX, im: W_MAX});
		eval_at('{re: -ONE, im: ONE});
	endtask

	task automatic test_random_phase(logic [3:0] deg, int n_items, bit burst);
		int slot;
		set_degree(deg);
		no_gaps = burst;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				slot = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
					: $urandom_range(0, MAX_DEG);
				load_coef(slot, rand_cplx());
			end else begin
				eval_at(rand_cplx());
			end
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_backpressure();
		wait_idle();
		rx_hold_req++;
		no_gaps = 1'b1;
		@(posedge clk);
		for (int i = 0; i < 12; i++)
			eval_at(rand_cplx());
		no_gaps = 1'b0;
		wait_idle();
	endtask

	initial begin
		n_evals = 0;
		n_loads = 0;
		rx_hold_req = 0;
		no_gaps = 1'b0;
		degree_reg = 4'd1;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_table();
		test_degree_edges();
		test_ignored_loads();
		test_random_phase(4'd8, 120, 1'b0);
		test_backpressure();
		test_random_phase(4'd3, 120, 1'b1);
		test_random_phase(4'($urandom_range(0, 15)), 120, 1'b0);
		test_random_phase(4'd0, 100, 1'b0);
		test_random_phase(4'd12, 120, 1'b0);
		test_random_phase(4'($urandom_range(1, 8)), 120, 1'b0);

		wait_idle();
		$display("covered %0d loads and %0d evaluations, degrees 0 to 15, incl. ignored slots",
			n_loads, n_evals);
		$display("checked %0d results, %0d with saturation, with stalls on both sides",
			n_checked, n_ovf);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
